[hw/rtl/cagc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cagc_pkg - shared types and constants of the card access gate controller
// Field widths, item and outcome codes, register map and reset values.
// ----------------------------------------------------------------------------
package cagc_pkg;

	// Field widths
	localparam int UID_W           = 56;
	localparam int UID_FIELD_BYTES = 7;
	localparam int LEN_W           = 3;
	localparam int TIME_W          = 16;
	localparam int OUTCOME_W       = 2;
	localparam int ADDR_W          = 4;
	localparam int DATA_W          = 32;
	localparam int REG_IDX_W       = 2;

	// Item kinds
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Card outcomes
	localparam logic [OUTCOME_W-1:0] OUTCOME_NONE     = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_ENROLLED = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_GRANTED  = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUTCOME_DENIED   = 2'd3;

	// Register indexes (byte address is 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_OPEN_TIME   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_NOTICE_TIME = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_READ_GAP    = 2'd2;

	// Register reset values
	localparam logic [TIME_W-1:0] OPEN_TIME_RST   = 16'd3000;
	localparam logic [TIME_W-1:0] NOTICE_TIME_RST = 16'd2500;
	localparam logic [TIME_W-1:0] READ_GAP_RST    = 16'd800;

	// Configuration seen by the engine
	typedef struct packed {
		logic [TIME_W-1:0] open_time_ms;
		logic [TIME_W-1:0] notice_time_ms;
		logic [TIME_W-1:0] read_gap_ms;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic                 gate_is_open;
		logic                 granted_notice;
		logic                 denied_notice;
		logic [OUTCOME_W-1:0] card_outcome;
	} result_t;

endpackage : cagc_pkg
`default_nettype wire

[hw/rtl/cagc_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cagc_regs - configuration register file
// APB-style access to the open time, notice time and read gap registers.
// ----------------------------------------------------------------------------
module cagc_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cagc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [cagc_pkg::DATA_W-1:0] pwdata,
	output logic      [cagc_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output cagc_pkg::cfg_t                  cfg
);
	import cagc_pkg::*;

	logic [TIME_W-1:0]    open_time_q;
	logic [TIME_W-1:0]    notice_time_q;
	logic [TIME_W-1:0]    read_gap_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// Write the addressed register; drop writes beyond the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_time_q   <= OPEN_TIME_RST;
			notice_time_q <= NOTICE_TIME_RST;
			read_gap_q    <= READ_GAP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_OPEN_TIME:   open_time_q   <= pwdata[TIME_W-1:0];
				REG_NOTICE_TIME: notice_time_q <= pwdata[TIME_W-1:0];
				REG_READ_GAP:    read_gap_q    <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_OPEN_TIME:   prdata = DATA_W'(open_time_q);
			REG_NOTICE_TIME: prdata = DATA_W'(notice_time_q);
			REG_READ_GAP:    prdata = DATA_W'(read_gap_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.open_time_ms   = open_time_q;
	assign cfg.notice_time_ms = notice_time_q;
	assign cfg.read_gap_ms    = read_gap_q;

endmodule : cagc_regs
`default_nettype wire

[hw/rtl/cagc_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cagc_engine - gate, notice and enrollment state with its update logic
// Applies one registered item per fire pulse and presents the resulting flags.
// ----------------------------------------------------------------------------
module cagc_engine #(
	parameter int UID_BYTES = 7
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        fire,
	input  wire logic                        cmd,
	input  wire logic [cagc_pkg::UID_W-1:0]  card_uid,
	input  wire logic [cagc_pkg::LEN_W-1:0]  card_uid_len,
	input  cagc_pkg::cfg_t                   cfg,
	output cagc_pkg::result_t                result
);
	import cagc_pkg::*;

	// Bytes kept and compared: the configured count, never beyond the field
	localparam int STORE_BYTES = (UID_BYTES < UID_FIELD_BYTES) ? UID_BYTES : UID_FIELD_BYTES;
	localparam int STORE_W     = STORE_BYTES * 8;

	logic                 enrolled_q;
	logic [STORE_W-1:0]   enrolled_uid_q;
	logic [LEN_W-1:0]     enrolled_len_q;
	logic                 gate_open_q;
	logic [TIME_W-1:0]    open_elapsed_q;
	logic                 granted_q;
	logic                 denied_q;
	logic [TIME_W-1:0]    notice_elapsed_q;
	logic [TIME_W-1:0]    since_read_q;

	logic                 enrolled_d;
	logic [STORE_W-1:0]   enrolled_uid_d;
	logic [LEN_W-1:0]     enrolled_len_d;
	logic                 gate_open_d;
	logic [TIME_W-1:0]    open_elapsed_d;
	logic                 granted_d;
	logic                 denied_d;
	logic [TIME_W-1:0]    notice_elapsed_d;
	logic [TIME_W-1:0]    since_read_d;
	logic [OUTCOME_W-1:0] outcome_d;

	logic [TIME_W-1:0]    open_inc;
	logic [TIME_W-1:0]    notice_inc;
	logic [TIME_W-1:0]    since_inc;
	logic [STORE_W-1:0]   uid_masked;
	logic                 bytes_match;
	logic                 read_ok;

	// Saturating millisecond counters
	assign open_inc   = (open_elapsed_q == '1) ? open_elapsed_q : open_elapsed_q + TIME_W'(1);
	assign notice_inc = (notice_elapsed_q == '1) ? notice_elapsed_q
	                                              : notice_elapsed_q + TIME_W'(1);
	assign since_inc  = (since_read_q == '1) ? since_read_q : since_read_q + TIME_W'(1);

	// Keep only the bytes below the card length
	always_comb begin
		for (int i = 0; i < STORE_BYTES; i++) begin
			if (LEN_W'(i) < card_uid_len)
				uid_masked[i*8 +: 8] = card_uid[i*8 +: 8];
			else
				uid_masked[i*8 +: 8] = 8'h00;
		end
	end

	// Stored bytes above the enrolled length are zero, so one compare suffices
	assign bytes_match = (card_uid_len == enrolled_len_q) && (uid_masked == enrolled_uid_q);
	assign read_ok     = (since_read_q >= cfg.read_gap_ms);

	// Next state for the item in the input register
	always_comb begin
		enrolled_d       = enrolled_q;
		enrolled_uid_d   = enrolled_uid_q;
		enrolled_len_d   = enrolled_len_q;
		gate_open_d      = gate_open_q;
		open_elapsed_d   = open_elapsed_q;
		granted_d        = granted_q;
		denied_d         = denied_q;
		notice_elapsed_d = notice_elapsed_q;
		since_read_d     = since_read_q;
		outcome_d        = OUTCOME_NONE;

		if (cmd == CMD_TICK) begin
			since_read_d     = since_inc;
			open_elapsed_d   = open_inc;
			notice_elapsed_d = notice_inc;
			if (gate_open_q && (open_inc >= cfg.open_time_ms))
				gate_open_d = 1'b0;
			if ((granted_q || denied_q) && (notice_inc >= cfg.notice_time_ms)) begin
				granted_d = 1'b0;
				denied_d  = 1'b0;
			end
		end else if (read_ok) begin
			since_read_d = '0;
			if (!enrolled_q || bytes_match) begin
				// Enroll the first card, or grant a matching one
				if (!enrolled_q) begin
					enrolled_d     = 1'b1;
					enrolled_uid_d = uid_masked;
					enrolled_len_d = card_uid_len;
					outcome_d      = OUTCOME_ENROLLED;
				end else begin
					outcome_d      = OUTCOME_GRANTED;
				end
				gate_open_d      = 1'b1;
				open_elapsed_d   = '0;
				granted_d        = 1'b1;
				denied_d         = 1'b0;
				notice_elapsed_d = '0;
			end else begin
				denied_d         = 1'b1;
				granted_d        = 1'b0;
				notice_elapsed_d = '0;
				outcome_d        = OUTCOME_DENIED;
			end
		end
	end

	// Commit the state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enrolled_q       <= 1'b0;
			enrolled_uid_q   <= '0;
			enrolled_len_q   <= '0;
			gate_open_q      <= 1'b0;
			open_elapsed_q   <= '0;
			granted_q        <= 1'b0;
			denied_q         <= 1'b0;
			notice_elapsed_q <= '0;
			since_read_q     <= '0;
		end else if (fire) begin
			enrolled_q       <= enrolled_d;
			enrolled_uid_q   <= enrolled_uid_d;
			enrolled_len_q   <= enrolled_len_d;
			gate_open_q      <= gate_open_d;
			open_elapsed_q   <= open_elapsed_d;
			granted_q        <= granted_d;
			denied_q         <= denied_d;
			notice_elapsed_q <= notice_elapsed_d;
			since_read_q     <= since_read_d;
		end
	end

	assign result.gate_is_open   = gate_open_d;
	assign result.granted_notice = granted_d;
	assign result.denied_notice  = denied_d;
	assign result.card_outcome   = outcome_d;

endmodule : cagc_engine
`default_nettype wire

[hw/rtl/card_access_gate_controller_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// card_access_gate_controller_core - card access gate controller
// Enrolls the first card, grants matching cards, denies others and times the
// gate and notices on millisecond ticks.
//
//   Channel  Direction  Handshake                  Payload
//   item     in         item_valid / item_stall    cmd, card_uid, card_uid_len
//   result   out        result_valid / result_stall gate_is_open, granted_notice,
//                                                  denied_notice, card_outcome
//   config   in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One item per cycle while the result is not stalled; each item passes from the
// input register through the state update into the result register. The state
// registers update as the item leaves the input register. Reset clears the valid
// bits and engine state and loads the register defaults. A stalled result holds
// the result register; the input register then fills and stalls.
// ----------------------------------------------------------------------------
module card_access_gate_controller_core #(
	parameter int UID_BYTES = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// item channel
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic                          cmd,
	input  wire logic [cagc_pkg::UID_W-1:0]    card_uid,
	input  wire logic [cagc_pkg::LEN_W-1:0]    card_uid_len,
	// result channel
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               gate_is_open,
	output logic                               granted_notice,
	output logic                               denied_notice,
	output logic [cagc_pkg::OUTCOME_W-1:0]     card_outcome,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cagc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [cagc_pkg::DATA_W-1:0]   pwdata,
	output logic      [cagc_pkg::DATA_W-1:0]   prdata,
	output logic                               pready
);
	import cagc_pkg::*;

	logic              valid_s1;
	logic              cmd_s1;
	logic [UID_W-1:0]  uid_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           res_next;
	cfg_t              cfg;
	logic              out_free;
	logic              advance;
	logic              load_s1;

	// Move the staged item when the result register can take it
	assign out_free   = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign load_s1    = item_valid && !item_stall;

	cagc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cagc_engine #(
		.UID_BYTES (UID_BYTES)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.cmd          (cmd_s1),
		.card_uid     (uid_s1),
		.card_uid_len (len_s1),
		.cfg          (cfg),
		.result       (res_next)
	);

	// Input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1 <= cmd;
			uid_s1 <= card_uid;
			len_s1 <= card_uid_len;
		end
	end

	// Result register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid   = valid_s2;
	assign gate_is_open   = res_s2.gate_is_open;
	assign granted_notice = res_s2.granted_notice;
	assign denied_notice  = res_s2.denied_notice;
	assign card_outcome   = res_s2.card_outcome;

endmodule : card_access_gate_controller_core
`default_nettype wire
